/* rtl/svl_pkg.sv */
// Package for the sorted value list: capacity, widths, operation codes
// and the command struct broadcast to every list cell. No dependencies.
package svl_pkg;

    localparam int CAPACITY = 32;
    localparam int VAL_W    = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int OCNT_W   = 6;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } t_op;

    typedef struct packed {
        logic                    ins;
        logic                    rem;
        logic signed [VAL_W-1:0] value;
    } t_cell_cmd;

endpackage

/* rtl/sorted_value_list.sv */
// Sorted value list top level: a chain of svl_cell instances and the
// result register. Depends on svl_pkg and svl_cell.
// An accepted beat updates the cells, then the result registers.
// One operation per cycle unless stalled; every cell compares in parallel.
// Reset: synchronous, active low; clears the cell valid bits and the count.
module sorted_value_list (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic                             i_operation,
    input  logic signed [svl_pkg::VAL_W-1:0]  i_value,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic                             o_success,
    output logic [svl_pkg::OCNT_W-1:0]       o_entry_count,
    output logic                             o_is_empty,
    output logic signed [svl_pkg::VAL_W-1:0] o_smallest,
    output logic signed [svl_pkg::VAL_W-1:0] o_largest
);

    localparam int N = svl_pkg::CAPACITY;

    logic signed [svl_pkg::VAL_W-1:0] w_val [N];
    logic [N-1:0]                     w_vld;
    logic [N-1:0]                     w_after;
    logic [N-1:0]                     w_match;
    svl_pkg::t_cell_cmd               w_cmd;
    logic                             w_acc;
    logic                             w_is_rem;
    logic                             w_ok;
    logic                             w_load;
    logic signed [svl_pkg::VAL_W-1:0] w_last;

    logic [svl_pkg::CNT_W-1:0]        r_count;
    logic [svl_pkg::CNT_W-1:0]        n_count;
    logic                             r_pend;
    logic                             r_succ;
    logic                             r_out_v;
    logic                             r_success;
    logic [svl_pkg::OCNT_W-1:0]       r_entry_count;
    logic                             r_is_empty;
    logic signed [svl_pkg::VAL_W-1:0] r_smallest;
    logic signed [svl_pkg::VAL_W-1:0] r_largest;

    assign o_stall  = r_pend && r_out_v && i_stall;
    assign w_acc    = i_valid && !o_stall;
    assign w_load   = r_pend && !(r_out_v && i_stall);
    assign w_is_rem = (i_operation == svl_pkg::OP_REMOVE);
    assign w_ok     = w_is_rem ? (|w_match) : !w_vld[N-1];

    assign w_cmd.ins   = w_acc && !w_is_rem && w_ok;
    assign w_cmd.rem   = w_acc && w_is_rem && w_ok;
    assign w_cmd.value = i_value;

    for (genvar g = 0; g < N; g++) begin : g_cell
        logic signed [svl_pkg::VAL_W-1:0] w_lv;
        logic signed [svl_pkg::VAL_W-1:0] w_rv;
        logic                             w_lvld;
        logic                             w_lafter;
        logic                             w_rvld;
        if (g == 0) begin : g_first
            assign w_lv     = '0;
            assign w_lvld   = 1'b0;
            assign w_lafter = 1'b0;
        end else begin : g_mid_l
            assign w_lv     = w_val[g-1];
            assign w_lvld   = w_vld[g-1];
            assign w_lafter = w_after[g-1];
        end
        if (g == N - 1) begin : g_last
            assign w_rv   = '0;
            assign w_rvld = 1'b0;
        end else begin : g_mid_r
            assign w_rv   = w_val[g+1];
            assign w_rvld = w_vld[g+1];
        end
        svl_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cmd       (w_cmd),
            .i_left_val  (w_lv),
            .i_left_vld  (w_lvld),
            .i_left_after(w_lafter),
            .i_right_val (w_rv),
            .i_right_vld (w_rvld),
            .o_val       (w_val[g]),
            .o_vld       (w_vld[g]),
            .o_after     (w_after[g]),
            .o_match     (w_match[g])
        );
    end

    always_comb begin
        w_last = '0;
        for (int k = 0; k < N; k++) begin
            if (w_vld[k] && ((k == N - 1) || !w_vld[(k + 1) % N])) begin
                w_last = w_last | w_val[k];
            end
        end
    end

    always_comb begin
        n_count = r_count;
        if (w_cmd.ins) begin
            n_count = r_count + 1'b1;
        end else if (w_cmd.rem) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_succ <= w_ok;
        end
        if (w_load) begin
            r_success     <= r_succ;
            r_entry_count <= svl_pkg::OCNT_W'(r_count);
            r_is_empty    <= !w_vld[0];
            r_smallest    <= w_vld[0] ? w_val[0] : '0;
            r_largest     <= w_last;
        end
        if (!i_rst_n) begin
            r_count <= '0;
            r_pend  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_acc) begin
                r_pend <= 1'b1;
            end else if (w_load) begin
                r_pend <= 1'b0;
            end
            if (w_load) begin
                r_out_v <= 1'b1;
            end else if (!i_stall) begin
                r_out_v <= 1'b0;
            end
        end
    end

    assign o_valid       = r_out_v;
    assign o_success     = r_success;
    assign o_entry_count = r_entry_count;
    assign o_is_empty    = r_is_empty;
    assign o_smallest    = r_smallest;
    assign o_largest     = r_largest;

`ifndef SYNTHESIS
    a_count_matches_cells: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_vld) == 32'(r_count))
        else $error("count differs from number of valid cells");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.ins |=> (r_count == $past(r_count) + 1'b1) && w_vld[0])
        else $error("insert did not grow the list");

    a_remove_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.rem |=> r_count == $past(r_count) - 1'b1)
        else $error("remove did not shrink the list");
`endif

endmodule

/* rtl/svl_cell.sv */
// One cell of the sorted list: holds one value and its valid bit and
// shifts right on insert or left on remove. Depends on svl_pkg.
module svl_cell (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  svl_pkg::t_cell_cmd              i_cmd,
    input  logic signed [svl_pkg::VAL_W-1:0] i_left_val,
    input  logic                            i_left_vld,
    input  logic                            i_left_after,
    input  logic signed [svl_pkg::VAL_W-1:0] i_right_val,
    input  logic                            i_right_vld,
    output logic signed [svl_pkg::VAL_W-1:0] o_val,
    output logic                            o_vld,
    output logic                            o_after,
    output logic                            o_match
);

    logic signed [svl_pkg::VAL_W-1:0] r_val;
    logic signed [svl_pkg::VAL_W-1:0] n_val;
    logic                             r_vld;
    logic                             n_vld;
    logic                             w_ge;

    assign o_after = !r_vld || (r_val > i_cmd.value);
    assign w_ge    = r_vld && (r_val >= i_cmd.value);
    assign o_match = r_vld && (r_val == i_cmd.value);
    assign o_val   = r_val;
    assign o_vld   = r_vld;

    always_comb begin
        n_val = r_val;
        n_vld = r_vld;
        if (i_cmd.ins && o_after) begin
            if (i_left_after) begin
                n_val = i_left_val;
                n_vld = i_left_vld;
            end else begin
                n_val = i_cmd.value;
                n_vld = 1'b1;
            end
        end else if (i_cmd.rem && w_ge) begin
            n_val = i_right_val;
            n_vld = i_right_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

endmodule
